// ===== hw/rtl/rxrw_pkg.sv =====
`timescale 1ns / 1ps

package rxrw_pkg;

  localparam logic [15:0] STOP_LENGTH = 16'hFFF0;
  localparam logic [15:0] PTR_BIAS    = 16'd16;
  localparam logic [15:0] HDR_BYTES   = 16'd4;
  localparam logic [15:0] CRC_BYTES   = 16'd4;
  localparam logic [16:0] RING_MIN    = 17'd8192;
  localparam logic [1:0]  RING_SEL_RESET = 2'd3;

  localparam logic [15:0] ST_OK     = 16'h0001;
  localparam logic [15:0] ST_ALIGN  = 16'h0002;
  localparam logic [15:0] ST_CRC    = 16'h0004;
  localparam logic [15:0] ST_LONG   = 16'h0008;
  localparam logic [15:0] ST_RUNT   = 16'h0010;
  localparam logic [15:0] ST_SYMBOL = 16'h0020;

  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_HEADER = 1'b1;

  typedef enum logic [1:0] {
    ACT_STOP    = 2'd0,
    ACT_ERROR   = 2'd1,
    ACT_DELIVER = 2'd2
  } action_t;

  typedef struct packed {
    action_t     action;
    logic        frame_error;
    logic        crc_error;
    logic        size_error;
    logic [15:0] data_offset;
    logic [15:0] first_len;
    logic [15:0] second_len;
    logic [15:0] deliver_len;
    logic [15:0] pointer_writeback;
  } result_t;

  typedef struct packed {
    logic        load;
    logic [15:0] value;
  } ptr_upd_t;

endpackage

// ===== hw/rtl/rxrw_hdr_calc.sv =====
`timescale 1ns / 1ps

module rxrw_hdr_calc
  import rxrw_pkg::*;
(
  input  logic        cmd,
  input  logic [15:0] hw_read_pointer,
  input  logic [15:0] pkt_status,
  input  logic [15:0] pkt_length,
  input  logic [15:0] read_ptr,
  input  logic [1:0]  ring_size_sel,
  output result_t     result,
  output ptr_upd_t    ptr_upd
);

  logic [16:0] ring_bytes;
  logic [15:0] ring_mask;
  logic [15:0] off;
  logic [16:0] end_sum;
  logic [16:0] first_wide;
  logic [15:0] fin;
  logic [15:0] rounded;
  logic [16:0] fin_up;

  always_comb begin
    ring_bytes = RING_MIN << ring_size_sel;
    ring_mask  = 16'(ring_bytes - 17'd1);

    // Data starts past the 4-byte header, wrapping at the ring end.
    off        = ((read_ptr & ring_mask) + HDR_BYTES) & ring_mask;
    end_sum    = {1'b0, off} + {1'b0, pkt_length};
    first_wide = ring_bytes - {1'b0, off};
    fin        = end_sum[15:0] & ring_mask;
    fin_up     = {1'b0, fin} + 17'd3;
    rounded    = fin_up[15:0] & ~16'd3 & ring_mask;

    result        = '0;
    result.action = ACT_STOP;
    ptr_upd.load  = 1'b0;
    ptr_upd.value = rounded;

    if (cmd == CMD_START) begin
      ptr_upd.load  = 1'b1;
      ptr_upd.value = (hw_read_pointer + PTR_BIAS) & ring_mask;
    end else if (pkt_length == STOP_LENGTH) begin
      result.action = ACT_STOP;
    end else if ((pkt_status & ST_OK) == '0) begin
      result.action      = ACT_ERROR;
      result.frame_error = (pkt_status & (ST_ALIGN | ST_SYMBOL)) != '0;
      result.crc_error   = (pkt_status & ST_CRC) != '0;
      result.size_error  = (pkt_status & (ST_LONG | ST_RUNT)) != '0;
    end else begin
      ptr_upd.load       = 1'b1;
      result.action      = ACT_DELIVER;
      result.data_offset = off;
      if (end_sum > ring_bytes) begin
        result.first_len  = first_wide[15:0];
        result.second_len = pkt_length - first_wide[15:0];
      end else begin
        result.first_len  = pkt_length;
        result.second_len = '0;
      end
      result.deliver_len = (pkt_length >= CRC_BYTES) ? (pkt_length - CRC_BYTES) : '0;
      result.pointer_writeback = rounded - PTR_BIAS;
    end
  end

endmodule

// ===== hw/rtl/rx_ring_header_walker.sv =====
`timescale 1ns / 1ps

// Channel  | Direction | Handshake             | Payload
// in_      | input     | in_valid / in_stall   | cmd, hw_read_pointer, pkt_status, pkt_length
// out_     | output    | out_valid / out_stall | action, error flags, offsets, lengths, writeback
// cfg_     | input     | cfg_we                | ring_size_sel (2 bits)
//
// One item per cycle unless stalled; a header's result goes via the input and result registers.
// An input register feeds the header decode and read-pointer update, which
// land in the result register; the pointer register closes the loop.
// Start items pass through the input register and give no result.
// Synchronous reset clears the valid bits, the read pointer and the ring size (64K).
// A stalled result holds the next header in the input register; start items still pass.

module rx_ring_header_walker
  import rxrw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [15:0] in_hw_read_pointer,
  input  logic [15:0] in_pkt_status,
  input  logic [15:0] in_pkt_length,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_action,
  output logic        out_frame_error,
  output logic        out_crc_error,
  output logic        out_size_error,
  output logic [15:0] out_data_offset,
  output logic [15:0] out_first_len,
  output logic [15:0] out_second_len,
  output logic [15:0] out_deliver_len,
  output logic [15:0] out_pointer_writeback
);

  logic [1:0]  ring_size_sel_r;
  logic [15:0] read_ptr_r;

  logic        stg_valid_r;
  logic        stg_cmd_r;
  logic [15:0] stg_hwp_r;
  logic [15:0] stg_status_r;
  logic [15:0] stg_len_r;

  logic        out_valid_r;
  logic        out_valid_nxt;
  result_t     out_r;

  result_t     calc_res;
  ptr_upd_t    calc_ptr;
  logic        advance;
  logic        in_take;

  rxrw_hdr_calc u_calc (
    .cmd             (stg_cmd_r),
    .hw_read_pointer (stg_hwp_r),
    .pkt_status      (stg_status_r),
    .pkt_length      (stg_len_r),
    .read_ptr        (read_ptr_r),
    .ring_size_sel   (ring_size_sel_r),
    .result          (calc_res),
    .ptr_upd         (calc_ptr)
  );

  // A start item needs no result slot, so it never waits on the output.
  assign advance  = stg_valid_r &&
                    ((stg_cmd_r == CMD_START) || !out_valid_r || !out_stall);
  assign in_stall = stg_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    if (advance && (stg_cmd_r == CMD_HEADER)) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_stall) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_size_sel_r <= RING_SEL_RESET;
      read_ptr_r      <= '0;
      stg_valid_r     <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        ring_size_sel_r <= cfg_wdata;
      end
      if (advance && calc_ptr.load) begin
        read_ptr_r <= calc_ptr.value;
      end
      if (in_take) begin
        stg_valid_r <= 1'b1;
      end else if (advance) begin
        stg_valid_r <= 1'b0;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stg_cmd_r    <= in_cmd;
      stg_hwp_r    <= in_hw_read_pointer;
      stg_status_r <= in_pkt_status;
      stg_len_r    <= in_pkt_length;
    end
    if (advance && (stg_cmd_r == CMD_HEADER)) begin
      out_r <= calc_res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_action            = out_r.action;
  assign out_frame_error       = out_r.frame_error;
  assign out_crc_error         = out_r.crc_error;
  assign out_size_error        = out_r.size_error;
  assign out_data_offset       = out_r.data_offset;
  assign out_first_len         = out_r.first_len;
  assign out_second_len        = out_r.second_len;
  assign out_deliver_len       = out_r.deliver_len;
  assign out_pointer_writeback = out_r.pointer_writeback;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    !stg_valid_r |-> !in_stall)
    else $error("input stalled with an empty input register");

  a_flags_only_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_r.action != ACT_ERROR) |->
      !out_frame_error && !out_crc_error && !out_size_error)
    else $error("error flags set on a non-error result");

  a_quiet_unless_deliver: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_r.action != ACT_DELIVER) |->
      (out_data_offset == '0) && (out_first_len == '0) && (out_second_len == '0) &&
      (out_deliver_len == '0) && (out_pointer_writeback == '0))
    else $error("payload fields set on a stop or error result");

  a_split_covers_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_r.action == ACT_DELIVER) && (out_deliver_len != '0) |->
      (16'(out_first_len + out_second_len) == 16'(out_deliver_len + CRC_BYTES)))
    else $error("split lengths do not add up to the packet length");

endmodule
